[hdl/fbpr_pkg.sv]
// Shared constants, types and helpers for the page-mode frame store.
package fbpr_pkg;

  localparam int COLUMNS   = 128;
  localparam int PAGES     = 8;
  localparam int ROWS      = PAGES * 8;
  localparam int DEPTH     = COLUMNS * PAGES;
  localparam int CMD_SLOTS = 3;

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int PG_W   = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int SLOT_W = $clog2(COLUMNS + CMD_SLOTS);

  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LOW   = 8'h00;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

  localparam logic [2:0] ACT_POINT   = 3'd0;
  localparam logic [2:0] ACT_FILL    = 3'd1;
  localparam logic [2:0] ACT_CLEAR   = 3'd2;
  localparam logic [2:0] ACT_REFRESH = 3'd3;
  localparam logic [2:0] ACT_TICK    = 3'd4;

  // refresh sequencer status toward the controller
  typedef struct packed {
    logic              busy;
    logic              is_data;
    logic              last;
    logic [PG_W-1:0]   page;
    logic [COL_W-1:0]  col;
    logic [7:0]        cmd_byte;
  } refr_status_t;

  // store address of column col, page pg
  function automatic logic [ADDR_W-1:0] addr_of(input logic [COL_W-1:0] col,
                                                input logic [PG_W-1:0] pg);
    addr_of = ADDR_W'(int'(col) * PAGES + int'(pg));
  endfunction

  // bits of page pg whose rows lie in [y_lo, y_hi]; bit 7 is the page's top row
  function automatic logic [7:0] page_mask(input logic [PG_W-1:0] pg,
                                           input logic [7:0] y_lo,
                                           input logic [7:0] y_hi);
    int row;
    page_mask = '0;
    for (int b = 0; b < 8; b++) begin
      row = (PAGES - 1 - int'(pg)) * 8 + (7 - b);
      page_mask[b] = (row >= int'(y_lo)) && (row <= int'(y_hi));
    end
  endfunction

endpackage

[hdl/fbpr_ram.sv]
// Single-port-write, registered-read RAM for the frame store.
module fbpr_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hdl/fbpr_refresh.sv]
// Refresh sequencer: page and slot counters, command byte generation.
module fbpr_refresh
  import fbpr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic         step,
  output refr_status_t status
);

  logic              busy;
  logic [PG_W-1:0]   page;
  logic [SLOT_W-1:0] slot;
  logic              slot_end;
  logic              page_end;

  assign slot_end = (slot == SLOT_W'(CMD_SLOTS + COLUMNS - 1));
  assign page_end = (page == PG_W'(PAGES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      page <= '0;
      slot <= '0;
    end else if (start) begin
      busy <= 1'b1;
      page <= '0;
      slot <= '0;
    end else if (step && busy) begin
      if (slot_end) begin
        slot <= '0;
        if (page_end) begin
          page <= '0;
          busy <= 1'b0;
        end else begin
          page <= page + 1'b1;
        end
      end else begin
        slot <= slot + 1'b1;
      end
    end
  end

  always_comb begin
    status.busy    = busy;
    status.page    = page;
    status.is_data = (slot >= SLOT_W'(CMD_SLOTS));
    status.col     = COL_W'(slot - SLOT_W'(CMD_SLOTS));
    status.last    = slot_end && page_end;
    case (slot)
      SLOT_W'(0): status.cmd_byte = CMD_PAGE_BASE + 8'(page);
      SLOT_W'(1): status.cmd_byte = CMD_COL_LOW;
      default:    status.cmd_byte = CMD_COL_HIGH;
    endcase
  end

endmodule

[hdl/mono_framebuffer_page_refresh.sv]
// Top level: frame store controller with point/fill/clear and refresh output.
//
// Input stream (s_*): one beat per action. s_tuser carries the action code
// (point, fill, clear, start refresh, tick); s_tdata carries the coordinates
// and the lit flag. Output stream (m_*): one beat per panel byte, produced
// only by a tick while a refresh is running; m_tuser marks data vs command,
// m_tlast marks the final data byte of a full refresh.
//
// Steps (one action at a time, s_tready high only while idle):
//   point            read, modify, write of one store byte
//   tick, command    S_EMIT loads the output register once it is free
//   tick, data byte  store read in S_TICK_RD, then S_EMIT loads the register
//   start refresh    restarts the sequencer (fill and clear also restart it)
//   fill             a store read and a write per byte, columns x PAGES bytes
//   clear            COLUMNS*PAGES bytes (one byte written a cycle)
// All store work goes through one shared address: read and write per modified byte.
// Reset: control is cleared and a clearing pass writes zero to all
// COLUMNS*PAGES (1024) store bytes, one a cycle; s_tready stays low meanwhile.
// Stall: the output register holds its beat until m_tready; new actions are
// still taken, and a tick waits for the register to free before it emits.
module mono_framebuffer_page_refresh
  import fbpr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // x_start[7:0], y_start[15:8], x_end[23:16],
                                 // y_end[31:24], lit[32], zero[39:33]
  input  logic [2:0]  s_tuser,   // action[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte[7:0]
  output logic        m_tuser,   // is_data[0]
  output logic        m_tlast    // frame_last
);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_PT_RD,
    S_PT_WR,
    S_FILL_RD,
    S_FILL_WR,
    S_TICK_RD,
    S_EMIT
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] addr;
  logic [7:0]        pt_mask;
  logic              lit;
  logic [COL_W-1:0]  fx;
  logic [COL_W-1:0]  fx_end;
  logic [PG_W-1:0]   fpg;
  logic [7:0]        fy_lo;
  logic [7:0]        fy_hi;

  // input fields
  logic [7:0] x_start, y_start, x_end, y_end;
  logic       in_lit;
  logic [2:0] action;
  logic       accept;

  assign x_start = s_tdata[7:0];
  assign y_start = s_tdata[15:8];
  assign x_end   = s_tdata[23:16];
  assign y_end   = s_tdata[31:24];
  assign in_lit  = s_tdata[32];
  assign action  = s_tuser;
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  // clipped rectangle corners
  logic [7:0] xe_clip, ye_clip;
  logic       fill_empty;
  assign xe_clip    = (int'(x_end) > COLUMNS - 1) ? 8'(COLUMNS - 1) : x_end;
  assign ye_clip    = (int'(y_end) > ROWS - 1) ? 8'(ROWS - 1) : y_end;
  assign fill_empty = (x_start > xe_clip) || (y_start > ye_clip);

  // point target
  logic            pt_on_screen;
  logic [PG_W-1:0] pt_pg;
  assign pt_on_screen = (int'(x_start) < COLUMNS) && (int'(y_start) < ROWS);
  assign pt_pg        = PG_W'(PAGES - 1 - int'(y_start[7:3]));

  // refresh sequencer
  refr_status_t rs;
  logic         refr_start;
  logic         refr_step;
  logic         out_free;

  assign out_free   = !m_tvalid || m_tready;
  assign refr_start = accept && (action == ACT_FILL || action == ACT_CLEAR ||
                                 action == ACT_REFRESH);
  assign refr_step  = (state == S_EMIT) && out_free;

  fbpr_refresh u_refresh (
    .clk    (clk),
    .rst    (rst),
    .start  (refr_start),
    .step   (refr_step),
    .status (rs)
  );

  // frame store: read always at addr; write-back on the same address
  logic       we;
  logic [7:0] wdata;
  logic [7:0] rdata;
  logic [7:0] mod_mask;

  assign mod_mask = (state == S_FILL_WR) ? page_mask(fpg, fy_lo, fy_hi) : pt_mask;

  always_comb begin
    we    = 1'b0;
    wdata = lit ? (rdata | mod_mask) : (rdata & ~mod_mask);
    if (state == S_CLR) begin
      we    = 1'b1;
      wdata = '0;
    end else if (state == S_PT_WR || state == S_FILL_WR) begin
      we = 1'b1;
    end
  end

  fbpr_ram #(
    .DEPTH (DEPTH),
    .WIDTH (8)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (addr),
    .wdata (wdata),
    .raddr (addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      addr     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // output register drains on m_tready; S_EMIT reloads it
      if (m_tready && state != S_EMIT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          if (addr == ADDR_W'(DEPTH - 1)) begin
            addr  <= '0;
            state <= S_IDLE;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            lit <= in_lit;
            case (action)
              ACT_POINT: begin
                if (pt_on_screen) begin
                  addr    <= addr_of(COL_W'(x_start), pt_pg);
                  pt_mask <= page_mask(pt_pg, y_start, y_start);
                  state   <= S_PT_RD;
                end
              end
              ACT_FILL: begin
                fx     <= COL_W'(x_start);
                fx_end <= COL_W'(xe_clip);
                fpg    <= '0;
                fy_lo  <= y_start;
                fy_hi  <= ye_clip;
                addr   <= addr_of(COL_W'(x_start), '0);
                if (!fill_empty) begin
                  state <= S_FILL_RD;
                end
              end
              ACT_CLEAR: begin
                addr  <= '0;
                state <= S_CLR;
              end
              ACT_TICK: begin
                if (rs.busy) begin
                  if (rs.is_data) begin
                    addr  <= addr_of(rs.col, rs.page);
                    state <= S_TICK_RD;
                  end else begin
                    state <= S_EMIT;
                  end
                end
              end
              default: ;  // refresh start handled by the sequencer; others ignored
            endcase
          end
        end
        S_PT_RD:   state <= S_PT_WR;
        S_PT_WR:   state <= S_IDLE;
        S_FILL_RD: state <= S_FILL_WR;
        S_FILL_WR: begin
          if (fpg == PG_W'(PAGES - 1)) begin
            fpg <= '0;
            if (fx == fx_end) begin
              state <= S_IDLE;
            end else begin
              fx    <= fx + 1'b1;
              addr  <= addr_of(fx + 1'b1, '0);
              state <= S_FILL_RD;
            end
          end else begin
            fpg   <= fpg + 1'b1;
            addr  <= addr_of(fx, fpg + 1'b1);
            state <= S_FILL_RD;
          end
        end
        S_TICK_RD: state <= S_EMIT;
        S_EMIT: begin
          // store byte stays valid here: addr held, no writes
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= rs.is_data ? rdata : rs.cmd_byte;
            m_tuser  <= rs.is_data;
            m_tlast  <= rs.last;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hdl/fbpr_checker.sv]
// Port-level checks for the frame store block, bound to the top level.
module fbpr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // output register empty and clearing pass running right after reset
  a_reset_out: assert property (@(posedge clk) disable iff (rst) $past(rst) |-> !m_tvalid)
    else $error("output beat present right after reset");

  a_reset_sweep: assert property (@(posedge clk) disable iff (rst) $past(rst) |-> !s_tready)
    else $error("input taken during post-reset clearing pass");

  // end of frame only on a data byte
  a_last_is_data: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && m_tlast |-> m_tuser)
    else $error("frame end flagged on a command byte");

  // command bytes are page select or column address bytes only
  a_cmd_code: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && !m_tuser |-> (m_tdata[7:4] == 4'hB || m_tdata == 8'h00 ||
                                m_tdata == 8'h10))
    else $error("unexpected command byte");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                                $stable(m_tlast))
    else $error("stalled output beat changed");

endmodule

bind mono_framebuffer_page_refresh fbpr_checker u_fbpr_checker (.*);
